@@ rtl/core/scsl_pkg.sv @@
`timescale 1ns / 1ps

package scsl_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned ACTION_W = 3;

    localparam logic [ACTION_W-1:0] ACT_PUSH   = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_POP    = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_PEEK   = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_FIND   = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_INSERT = 3'd4;
    localparam logic [ACTION_W-1:0] ACT_REMOVE = 3'd5;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_FROM_LOW,
        CELL_FROM_HIGH,
        CELL_LOAD
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        logic     search;
        logic     occ;
    } cell_ctrl_t;

endpackage

@@ rtl/core/scsl_cell.sv @@
`timescale 1ns / 1ps

module scsl_cell
    import scsl_pkg::*;
(
    input  logic              clk,
    input  cell_ctrl_t        ctrl,
    input  logic [BYTE_W-1:0] key,
    input  logic [BYTE_W-1:0] value,
    input  logic [BYTE_W-1:0] low_entry,
    input  logic [BYTE_W-1:0] high_entry,
    output logic [BYTE_W-1:0] entry,
    output logic              hit
);

    logic [BYTE_W-1:0] entry_reg;
    logic [BYTE_W-1:0] entry_next;
    logic              hit_reg;
    logic              hit_next;

    always_comb
    begin
        case (ctrl.op)
            CELL_HOLD:      entry_next = entry_reg;
            CELL_FROM_LOW:  entry_next = low_entry;
            CELL_FROM_HIGH: entry_next = high_entry;
            CELL_LOAD:      entry_next = value;
            default:        entry_next = entry_reg;
        endcase
        hit_next = ctrl.search ? (ctrl.occ && (entry_reg == key)) : hit_reg;
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
        hit_reg   <= hit_next;
    end

    assign entry = entry_reg;
    assign hit   = hit_reg;

endmodule

@@ rtl/core/searchable_char_stack_list.sv @@
`timescale 1ns / 1ps

// channel  dir  fields                 transaction
// in       in   action, value, anchor  in_valid && !in_stall
// out      out  ok, data, count        out_valid && !out_stall
//
// per transaction, every cell compares its byte against the key in the accept cycle
// and registers its hit; the cell row then shifts or loads in the apply state
// in_stall is high during the apply state, which waits while a result is held by out_stall
// the top entry sits in cell 0, so pop and peek read one fixed cell
// reset clears the fill count and the output valid; cell contents are not cleared

module searchable_char_stack_list
    import scsl_pkg::*;
#(
    parameter int CAPACITY = 64
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [ACTION_W-1:0]           action,
    input  logic [BYTE_W-1:0]             value,
    input  logic [BYTE_W-1:0]             anchor,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          ok,
    output logic [BYTE_W-1:0]             data,
    output logic [$clog2(CAPACITY+1)-1:0] count
);

    localparam int CW = $clog2(CAPACITY + 1);

    typedef enum logic {
        ST_IDLE,
        ST_APPLY
    } state_t;

    state_t                state_reg;
    state_t                state_next;
    logic [CW-1:0]         fill_reg;
    logic [CW-1:0]         fill_next;
    logic [ACTION_W-1:0]   action_reg;
    logic [ACTION_W-1:0]   action_next;
    logic [BYTE_W-1:0]     value_reg;
    logic [BYTE_W-1:0]     value_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic                  ok_reg;
    logic                  ok_next;
    logic [BYTE_W-1:0]     data_reg;
    logic [BYTE_W-1:0]     data_next;
    logic [CW-1:0]         count_reg;
    logic [CW-1:0]         count_next;

    logic                  accept;
    logic                  fire;
    logic [BYTE_W-1:0]     key;
    logic                  found;
    logic                  not_full;
    logic                  not_empty;
    logic [BYTE_W-1:0]     entry_w [CAPACITY];
    logic [CAPACITY-1:0]   hit_w;
    logic [CAPACITY-1:0]   hit_rev;
    logic [CAPACITY-1:0]   low_mask;
    logic [CAPACITY-1:0]   at_or_above;
    cell_op_t              cell_op [CAPACITY];

    assign accept    = in_valid && !in_stall;
    assign fire      = (state_reg == ST_APPLY) && (!out_valid_reg || !out_stall);
    assign key       = (action == ACT_INSERT) ? anchor : value;
    assign found     = |hit_w;
    assign not_full  = fill_reg < CW'(CAPACITY);
    assign not_empty = fill_reg != '0;

    // highest hitting cell holds the lowest slot; mark it and every cell above it
    always_comb
    begin
        for (int c = 0; c < CAPACITY; c++)
        begin
            hit_rev[c] = hit_w[CAPACITY-1-c];
        end
        low_mask = hit_rev ^ (hit_rev - CAPACITY'(1));
        for (int c = 0; c < CAPACITY; c++)
        begin
            at_or_above[c] = low_mask[CAPACITY-1-c];
        end
    end

    always_comb
    begin
        for (int c = 0; c < CAPACITY; c++)
        begin
            cell_op[c] = CELL_HOLD;
        end
        fill_next  = fill_reg;
        ok_next    = 1'b0;
        data_next  = '0;
        if (fire)
        begin
            case (action_reg)
                ACT_PUSH:
                begin
                    if (not_full)
                    begin
                        for (int c = 0; c < CAPACITY; c++)
                        begin
                            cell_op[c] = CELL_FROM_LOW;
                        end
                        fill_next = fill_reg + CW'(1);
                        ok_next   = 1'b1;
                    end
                end
                ACT_POP:
                begin
                    if (not_empty)
                    begin
                        for (int c = 0; c < CAPACITY; c++)
                        begin
                            cell_op[c] = CELL_FROM_HIGH;
                        end
                        fill_next = fill_reg - CW'(1);
                        ok_next   = 1'b1;
                        data_next = entry_w[0];
                    end
                end
                ACT_PEEK:
                begin
                    if (not_empty)
                    begin
                        ok_next   = 1'b1;
                        data_next = entry_w[0];
                    end
                end
                ACT_FIND:
                begin
                    ok_next = found;
                end
                ACT_INSERT:
                begin
                    if (not_full && found)
                    begin
                        for (int c = 0; c < CAPACITY; c++)
                        begin
                            if (at_or_above[c] && hit_w[c])
                            begin
                                cell_op[c] = CELL_LOAD;
                            end
                            else if (at_or_above[c])
                            begin
                                cell_op[c] = CELL_FROM_LOW;
                            end
                        end
                        fill_next = fill_reg + CW'(1);
                        ok_next   = 1'b1;
                    end
                end
                ACT_REMOVE:
                begin
                    if (found)
                    begin
                        for (int c = 0; c < CAPACITY; c++)
                        begin
                            if (at_or_above[c])
                            begin
                                cell_op[c] = CELL_FROM_HIGH;
                            end
                        end
                        fill_next = fill_reg - CW'(1);
                        ok_next   = 1'b1;
                    end
                end
                default:
                begin
                    ok_next = 1'b0;
                end
            endcase
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        action_next    = action_reg;
        value_next     = value_reg;
        out_valid_next = out_valid_reg && out_stall;
        count_next     = count_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next  = ST_APPLY;
                    action_next = action;
                    value_next  = value;
                end
            end
            ST_APPLY:
            begin
                if (fire)
                begin
                    state_next     = ST_IDLE;
                    out_valid_next = 1'b1;
                    count_next     = fill_next;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fill_reg      <= '0;
            action_reg    <= ACT_PUSH;
            value_reg     <= '0;
            out_valid_reg <= 1'b0;
            ok_reg        <= 1'b0;
            data_reg      <= '0;
            count_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            action_reg    <= action_next;
            value_reg     <= value_next;
            out_valid_reg <= out_valid_next;
            count_reg     <= count_next;
            if (fire)
            begin
                ok_reg   <= ok_next;
                data_reg <= data_next;
            end
        end
    end

    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        cell_ctrl_t        ctrl;
        logic [BYTE_W-1:0] low_entry;
        logic [BYTE_W-1:0] high_entry;

        assign ctrl.op     = cell_op[g];
        assign ctrl.search = accept;
        assign ctrl.occ    = CW'(g) < fill_reg;

        if (g == 0)
        begin : g_bottom
            assign low_entry = value_reg;
        end
        else
        begin : g_inner_low
            assign low_entry = entry_w[g-1];
        end

        if (g == CAPACITY - 1)
        begin : g_end
            assign high_entry = entry_w[g];
        end
        else
        begin : g_inner_high
            assign high_entry = entry_w[g+1];
        end

        scsl_cell u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .key        (key),
            .value      (value_reg),
            .low_entry  (low_entry),
            .high_entry (high_entry),
            .entry      (entry_w[g]),
            .hit        (hit_w[g])
        );
    end

    assign in_stall  = state_reg != ST_IDLE;
    assign out_valid = out_valid_reg;
    assign ok        = ok_reg;
    assign data      = data_reg;
    assign count     = count_reg;

endmodule

@@ rtl/core/scsl_checker.sv @@
`timescale 1ns / 1ps

module scsl_checker
    import scsl_pkg::*;
#(
    parameter int CAPACITY = 64
)
(
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_stall,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic                          ok,
    input logic [BYTE_W-1:0]             data,
    input logic [$clog2(CAPACITY+1)-1:0] count
);

    localparam int CW = $clog2(CAPACITY + 1);

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (count <= CW'(CAPACITY)))
        else $error("count above capacity");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("second transaction taken during shift cycle");

    a_result_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result without a transaction in flight");

    a_fail_no_data: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !ok) |-> (data == '0))
        else $error("failed transaction carries data");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(data) && $stable(count)))
        else $error("stalled result changed");

endmodule

bind searchable_char_stack_list scsl_checker #(.CAPACITY(CAPACITY)) u_scsl_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .ok        (ok),
    .data      (data),
    .count     (count)
);
